// ===== rtl/core/hashed_block_to_file_offset_defines.svh =====
// Assertion macros for the hashed block to file offset translator.
// Used by the top level only; expects clk and rst in scope.
`ifndef HASHED_BLOCK_TO_FILE_OFFSET_DEFINES_SVH
`define HASHED_BLOCK_TO_FILE_OFFSET_DEFINES_SVH

// Same-cycle implication, off during reset.
`define HBFO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbfo: same-cycle check failed");

// Next-cycle implication, off during reset.
`define HBFO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbfo: next-cycle check failed");

`endif

// ===== rtl/core/hbfo_pkg.sv =====
// Shared constants, types and helpers of the block to file offset translator.
// No dependencies.
`timescale 1ns / 1ps

package hbfo_pkg;

  localparam int TABLE_ENTRIES_DEF = 170;
  localparam int INDEX_BITS        = 24;
  localparam int IDX_W             = INDEX_BITS;
  localparam int HDR_W             = 24;
  localparam int BLOCK_SHIFT       = 12;
  localparam int BLK_W             = 26;
  localparam int PB_W              = 25;
  localparam int BO_W              = 38;
  localparam int HDR_BLK_W         = HDR_W + 1 - BLOCK_SHIFT;
  localparam int DIV_DEPTH         = 6;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_L0   = 2'd1;
  localparam logic [1:0] KIND_L1   = 2'd2;
  localparam logic [1:0] KIND_L2   = 2'd3;

  localparam logic REG_HEADER_BYTES  = 1'b0;
  localparam logic REG_SINGLE_TABLES = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] q1;
    logic [IDX_W-1:0] q2;
  } item_t;

  typedef struct packed {
    logic [HDR_BLK_W-1:0] hdr_blocks;
    logic                 dbl;
  } cfg_t;

  // Multiply by blocks per table (one or two).
  function automatic logic [BLK_W-1:0] by_tables(input logic [BLK_W-1:0] x, input logic dbl);
    by_tables = dbl ? {x[BLK_W-2:0], 1'b0} : x;
  endfunction

endpackage

// ===== rtl/core/hbfo_cdiv.sv =====
// Two-stage divider by a constant: reciprocal multiply, then one-step correction.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module hbfo_cdiv #(
  parameter int WIDTH   = 24,
  parameter int DIVISOR = 170
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] x,
  output logic [WIDTH-1:0] q
);

  localparam int DB = $clog2(DIVISOR + 1);
  localparam int RW = WIDTH + DB;
  localparam longint unsigned RECIP_L = (64'd1 << WIDTH) / DIVISOR;
  localparam logic [WIDTH-1:0] RECIP = RECIP_L[WIDTH-1:0];

  logic [2*WIDTH-1:0] prod_full;
  logic [WIDTH-1:0]   prod_hi;
  logic [WIDTH-1:0]   x_hold;
  logic [RW-1:0]      qt;
  logic [RW-1:0]      rem;
  logic               bump;
  logic [WIDTH-1:0]   q_next;

  assign prod_full = (2*WIDTH)'(x) * (2*WIDTH)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi <= prod_full[2*WIDTH-1:WIDTH];
      x_hold  <= x;
    end
  end

  always_comb begin
    qt     = RW'(prod_hi) * RW'(DIVISOR);
    rem    = RW'(x_hold) - qt;
    bump   = rem >= RW'(DIVISOR);
    q_next = prod_hi + WIDTH'(bump);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/hbfo_map.sv =====
// Final three stages: table products, physical block selection, byte offset.
// Depends on hbfo_pkg.
`timescale 1ns / 1ps

module hbfo_map #(
  parameter int TABLE_ENTRIES = hbfo_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  hbfo_pkg::item_t              item,
  input  logic [hbfo_pkg::IDX_W-1:0]   q3,
  input  hbfo_pkg::cfg_t               cfg,
  output logic                         valid,
  output logic [hbfo_pkg::PB_W-1:0]    physical_block,
  output logic [hbfo_pkg::BO_W-1:0]    byte_offset
);

  import hbfo_pkg::*;

  localparam logic [BLK_W-1:0] T_C   = BLK_W'(TABLE_ENTRIES);
  localparam logic [BLK_W-1:0] TT_C  = BLK_W'(TABLE_ENTRIES * TABLE_ENTRIES);
  localparam logic [BLK_W-1:0] T1_C  = BLK_W'(TABLE_ENTRIES + 1);
  localparam logic [BLK_W-1:0] ONE_C = BLK_W'(1);

  logic [2:0] v;

  // stage 1: products
  item_t            it1;
  logic [IDX_W-1:0] q3_1;
  logic [BLK_W-1:0] pa, pb, pc;

  // stage 2: block number
  logic [BLK_W-1:0] blk, blk_next;
  logic [BLK_W-1:0] q1w, q2w, q3w, cnt, step0, step1;

  // stage 3: offset
  logic [BLK_W-1:0] sum_blocks;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1  <= item;
      q3_1 <= q3;
      pa   <= BLK_W'(item.q1) * T_C;
      pb   <= BLK_W'(item.q2) * TT_C;
      pc   <= BLK_W'(item.q2) * T1_C;
    end
  end

  always_comb begin
    q1w   = BLK_W'(it1.q1);
    q2w   = BLK_W'(it1.q2);
    q3w   = BLK_W'(q3_1);
    step0 = T_C + by_tables(ONE_C, cfg.dbl);
    step1 = TT_C + by_tables(T1_C, cfg.dbl);
    cnt   = '0;
    unique case (it1.kind)
      KIND_DATA: begin
        cnt = q1w + ONE_C + ((q1w != '0) ? q2w + ONE_C : '0)
            + ((q2w != '0) ? q3w + ONE_C : '0);
        blk_next = BLK_W'(it1.idx) + by_tables(cnt, cfg.dbl);
      end
      KIND_L0: begin
        cnt = q1w + q2w + ONE_C + ((q2w != '0) ? ONE_C : '0);
        blk_next = (q1w == '0) ? '0 : pa + by_tables(cnt, cfg.dbl);
      end
      KIND_L1: begin
        blk_next = (q2w == '0) ? step0 : pb + by_tables(pc + ONE_C, cfg.dbl);
      end
      KIND_L2: begin
        blk_next = step1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk <= blk_next;
    end
  end

  assign sum_blocks = blk + BLK_W'(cfg.hdr_blocks);

  always_ff @(posedge clk) begin
    if (en) begin
      physical_block <= blk[PB_W-1:0];
      byte_offset    <= {sum_blocks, {BLOCK_SHIFT{1'b0}}};
    end
  end

  assign valid = v[2];

endmodule

// ===== rtl/core/hashed_block_to_file_offset.sv =====
// Top level of the hashed block to file offset translator.
// Depends on hbfo_pkg, hbfo_cdiv, hbfo_map and the assertion macro header.
`timescale 1ns / 1ps

// Translates a logical data block number into the physical block number and byte
// offset of the data block or of the level 0, 1 or 2 hash table covering it.
// One transfer per cycle is taken while no result waits on rsp_ready; each request
// passes through three chained two-stage constant dividers (block/T, /T^2, /T^3),
// followed by a product stage, a block select stage and the offset register.
// The whole pipeline holds while a result waits on rsp_ready. Write the header
// size and table layout registers only while no transfer is in flight.
module hashed_block_to_file_offset #(
  parameter int TABLE_ENTRIES = hbfo_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   kind,
  input  logic [hbfo_pkg::IDX_W-1:0]   logical_block,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [hbfo_pkg::PB_W-1:0]    physical_block,
  output logic [hbfo_pkg::BO_W-1:0]    byte_offset,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [hbfo_pkg::HDR_W-1:0]   cfg_data
);

  import hbfo_pkg::*;
  `include "hashed_block_to_file_offset_defines.svh"

  logic                 en;
  logic [DIV_DEPTH-1:0] v;
  item_t                st [DIV_DEPTH];
  logic [IDX_W-1:0]     div1_q, div2_q, div3_q;
  cfg_t                 cfg;
  logic [HDR_W:0]       hdr_sum;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // configuration
  assign hdr_sum = (HDR_W+1)'(cfg_data) + (HDR_W+1)'((1 << BLOCK_SHIFT) - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hdr_blocks <= '0;
      cfg.dbl        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_BYTES:  cfg.hdr_blocks <= hdr_sum[HDR_W:BLOCK_SHIFT];
        REG_SINGLE_TABLES: cfg.dbl        <= ~cfg_data[0];
      endcase
    end
  end

  // divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DIV_DEPTH-2:0], req_valid && req_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= '{kind: kind, idx: logical_block, q1: '0, q2: '0};
      st[1] <= st[0];
      st[2] <= '{kind: st[1].kind, idx: st[1].idx, q1: div1_q, q2: st[1].q2};
      st[3] <= st[2];
      st[4] <= '{kind: st[3].kind, idx: st[3].idx, q1: st[3].q1, q2: div2_q};
      st[5] <= st[4];
    end
  end

  hbfo_cdiv #(.WIDTH(IDX_W), .DIVISOR(TABLE_ENTRIES)) u_div1 (
    .clk (clk),
    .en  (en),
    .x   (logical_block),
    .q   (div1_q)
  );

  hbfo_cdiv #(.WIDTH(IDX_W), .DIVISOR(TABLE_ENTRIES)) u_div2 (
    .clk (clk),
    .en  (en),
    .x   (div1_q),
    .q   (div2_q)
  );

  hbfo_cdiv #(.WIDTH(IDX_W), .DIVISOR(TABLE_ENTRIES)) u_div3 (
    .clk (clk),
    .en  (en),
    .x   (div2_q),
    .q   (div3_q)
  );

  hbfo_map #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_map (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (v[DIV_DEPTH-1]),
    .item           (st[DIV_DEPTH-1]),
    .q3             (div3_q),
    .cfg            (cfg),
    .valid          (rsp_valid),
    .physical_block (physical_block),
    .byte_offset    (byte_offset)
  );

  `HBFO_ASSERT_IMPL(a_div_low, v[1], (32'(div1_q) * 32'(TABLE_ENTRIES)) <= 32'(st[1].idx))
  `HBFO_ASSERT_IMPL(a_div_rem, v[1], (32'(st[1].idx) - 32'(div1_q) * 32'(TABLE_ENTRIES)) < 32'(TABLE_ENTRIES))
  `HBFO_ASSERT_IMPL(a_offset_match, rsp_valid, (byte_offset[PB_W+BLOCK_SHIFT-1:BLOCK_SHIFT] - PB_W'(cfg.hdr_blocks)) == physical_block)
  `HBFO_ASSERT_NEXT(a_stall_hold_pipe, !en && v[DIV_DEPTH-1], v[DIV_DEPTH-1])

endmodule

// ===== tb/tb_hashed_block_to_file_offset.sv =====
// Testbench for hashed_block_to_file_offset: random and corner lookups checked
// against a local block locator, across header and table layout settings.
// Depends on hbfo_pkg and the hashed_block_to_file_offset RTL.
`timescale 1ns / 1ps

module tb_hashed_block_to_file_offset;
  import hbfo_pkg::*;

  localparam longint unsigned TE = TABLE_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  typedef struct packed {
    logic [PB_W-1:0] pb;
    logic [BO_W-1:0] bo;
  } location_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] kind = KIND_DATA;
  logic [IDX_W-1:0] logical_block = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [PB_W-1:0] physical_block;
  logic [BO_W-1:0] byte_offset;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_HEADER_BYTES;
  logic [HDR_W-1:0] cfg_data = '0;

  lookup_t pending_lookups[$];
  location_t expected_locations[$];
  logic [HDR_W-1:0] hdr_cfg = '0;
  logic single_cfg = 1'b1;
  logic req_xfer = 1'b0;
  logic rsp_hold = 1'b0;
  logic pressure_on = 1'b0;
  int sender_pct = 0;
  int recv_pct = 0;
  int mismatch_count = 0;

  hashed_block_to_file_offset u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .kind(kind),
    .logical_block(logical_block),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .physical_block(physical_block),
    .byte_offset(byte_offset),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic location_t locate_block(input logic [1:0] k,
                                             input logic [IDX_W-1:0] index,
                                             input logic [HDR_W-1:0] hdr,
                                             input logic single);
    logic [63:0] idx, b, base, blk, t1, step0, step1, hdr_round, offset;
    int lvl;
    location_t loc;
    idx = 64'(index);
    b = single ? 64'd1 : 64'd2;
    t1 = TE * TE;
    step0 = TE + b;
    step1 = t1 + (TE + 64'd1) * b;
    case (k)
      KIND_DATA: begin
        blk = idx;
        base = TE;
        for (lvl = 0; lvl < 3; lvl++) begin
          blk += ((idx + base) / base) * b;
          if (idx < base) break;
          base *= TE;
        end
      end
      KIND_L0: begin
        if (idx < TE) begin
          blk = 64'd0;
        end else begin
          blk = (idx / TE) * step0 + (idx / t1 + 64'd1) * b;
          if (idx >= t1) blk += b;
        end
      end
      KIND_L1: blk = (idx < t1) ? step0 : (idx / t1) * step1 + b;
      default: blk = step1;
    endcase
    hdr_round = (64'(hdr) + 64'd4095) & ~64'd4095;
    offset = hdr_round + (blk << BLOCK_SHIFT);
    loc.pb = blk[PB_W-1:0];
    loc.bo = offset[BO_W-1:0];
    return loc;
  endfunction

  function automatic lookup_t random_lookup();
    lookup_t r;
    longint unsigned v;
    r.kind = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, 2 * TE + 5);
      6, 7: v = longint'($urandom_range(1, 98000)) * TE + $urandom_range(0, 2) - 1;
      8: v = longint'($urandom_range(1, 580)) * TE * TE + $urandom_range(0, 2) - 1;
      default: v = longint'($urandom_range(1, 3)) * TE * TE * TE + $urandom_range(0, 2) - 1;
    endcase
    r.idx = v[IDX_W-1:0];
    return r;
  endfunction

  always @(negedge clk) begin
    lookup_t next;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_xfer) begin
      if (pending_lookups.size() != 0 && $urandom_range(0, 99) >= sender_pct) begin
        next = pending_lookups.pop_front();
        kind <= next.kind;
        logical_block <= next.idx;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    location_t want;
    if (rst) begin
      req_xfer <= 1'b0;
      hdr_cfg <= '0;
      single_cfg <= 1'b1;
    end else begin
      req_xfer <= req_valid && req_ready;
      if (cfg_we) begin
        if (cfg_index == REG_HEADER_BYTES) hdr_cfg <= cfg_data;
        else single_cfg <= cfg_data[0];
      end
      if (req_valid && req_ready)
        expected_locations.insert(expected_locations.size(),
                                  locate_block(kind, logical_block, hdr_cfg, single_cfg));
      if (rsp_valid && rsp_ready) begin
        if (expected_locations.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual pb %0d offset %0d",
                   $time, physical_block, byte_offset);
          mismatch_count++;
        end else begin
          want = expected_locations.pop_front();
          if (physical_block !== want.pb) begin
            $display("%0t: physical_block expected %0d actual %0d",
                     $time, want.pb, physical_block);
            mismatch_count++;
          end
          if (byte_offset !== want.bo) begin
            $display("%0t: byte_offset expected %0d actual %0d",
                     $time, want.bo, byte_offset);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Hold the receiver off while the sender keeps offering.
  initial begin
    wait (pressure_on);
    @(negedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(negedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input logic index, input logic [HDR_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_lookups.size() != 0 || req_valid || expected_locations.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin sender_pct <= 0;  recv_pct <= 0;  end
      1: begin sender_pct <= 52; recv_pct <= 0;  end
      2: begin sender_pct <= 0;  recv_pct <= 52; end
      default: begin sender_pct <= 7; recv_pct <= 7; end
    endcase
  endtask

  initial begin
    logic [IDX_W-1:0] corner_idx [6];
    logic [HDR_W-1:0] hdr_set [9];
    logic single_set [9];
    lookup_t item;
    int p, i, k;
    corner_idx = '{IDX_W'(0), IDX_W'(TE - 1), IDX_W'(TE), IDX_W'(TE * TE - 1),
                   IDX_W'(TE * TE), {IDX_W{1'b1}}};
    hdr_set = '{HDR_W'(1), {HDR_W{1'b1}}, HDR_W'(0), HDR_W'(4096), HDR_W'(4095),
                HDR_W'(4097), HDR_W'(0), HDR_W'(0), HDR_W'(0)};
    single_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    for (p = 6; p < 9; p++) begin
      hdr_set[p] = HDR_W'($urandom_range(0, {HDR_W{1'b1}}));
      single_set[p] = 1'($urandom_range(0, 1));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner lookups under reset settings.
    set_idling(0);
    @(posedge clk);
    for (k = 0; k < 4; k++) begin
      for (i = 0; i < 6; i++) begin
        item.kind = 2'(k);
        item.idx = corner_idx[i];
        pending_lookups.insert(pending_lookups.size(), item);
      end
    end
    wait_idle();

    for (p = 0; p < 9; p++) begin
      write_reg(REG_HEADER_BYTES, hdr_set[p]);
      write_reg(REG_SINGLE_TABLES, HDR_W'(single_set[p]));
      set_idling((p + 1) % 4);
      @(posedge clk);
      for (i = 0; i < PHASE_ITEMS; i++)
        pending_lookups.insert(pending_lookups.size(), random_lookup());
      if (p == 3) pressure_on = 1'b1;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
